### hw/rtl/srra_pkg.sv
// Shared constants, types and helper functions for the sphere rotation remap address core.
// No dependencies; every other file in hw/rtl but srra_checker uses it by scoped names.
package srra_pkg;

  // Default and upper bound for the image size clamp
  localparam int MAX_DIM = 4096;

  // CORDIC iteration count and datapath widths
  localparam int STEPS = 30;
  localparam int PH_W  = 32;   // phase word, 2^32 per turn
  localparam int ROT_W = 34;   // rotation-mode CORDIC datapath
  localparam int VEC_W = 36;   // vectoring-mode CORDIC datapath
  localparam int Q_W   = 34;   // sphere coordinates, signed Q30
  localparam int DIM_W = 13;   // image size register
  localparam int CRD_W = 12;   // pixel coordinate

  localparam logic [29:0]        INV_GAIN = 30'd652032874;
  localparam logic signed [33:0] GAIN     = 34'sd1768195363;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ROT_Y = 3'd0,
    REG_ROT_X = 3'd1,
    REG_MAP_W = 3'd2,
    REG_MAP_H = 3'd3
  } cfg_reg_t;

  // Arctangent of 2^-i in phase units
  function automatic logic [31:0] atan_tab(input int i);
    case (i)
      0: return 32'h20000000;
      1: return 32'h12E4051E;
      2: return 32'h09FB385B;
      3: return 32'h051111D4;
      4: return 32'h028B0D43;
      5: return 32'h0145D7E1;
      6: return 32'h00A2F61E;
      7: return 32'h00517C55;
      8: return 32'h0028BE53;
      9: return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      15: return 32'h0000517D;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A30;
      19: return 32'h00000518;
      20: return 32'h0000028C;
      21: return 32'h00000146;
      22: return 32'h000000A3;
      23: return 32'h00000051;
      24: return 32'h00000029;
      25: return 32'h00000014;
      26: return 32'h0000000A;
      27: return 32'h00000005;
      28: return 32'h00000003;
      29: return 32'h00000001;
      default: return 32'h0;
    endcase
  endfunction

  // Q30 product, floor
  function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b;
    return 34'(p >>> 30);
  endfunction

  // Clamp an image size to [2, maxd] and return size minus one
  function automatic logic [12:0] clamp_m1(input logic [12:0] d, input int maxd);
    if (d < 13'd2) return 13'd1;
    if (int'(d) > maxd) return 13'(maxd - 1);
    return d - 13'd1;
  endfunction

endpackage

### hw/rtl/srra_div.sv
// Pipelined restoring divider: quotient of num * 2^Q_W / den, one bit per stage.
// Uses srra_pkg for widths. num must not exceed den.
module srra_div #(
  parameter int LANES = 2,
  parameter int NUM_W = srra_pkg::DIM_W,
  parameter int Q_W   = srra_pkg::PH_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num [LANES],
  input  logic [NUM_W-1:0] den [LANES],
  output logic             out_valid,
  output logic [Q_W:0]     quo [LANES]
);

  logic [Q_W:0] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Q_W-1:0], in_valid};
    end
  end

  assign out_valid = v[Q_W];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [NUM_W-1:0] rem  [0:Q_W];
    logic [Q_W-1:0]   q    [0:Q_W];
    logic             full [0:Q_W];

    // num equal to den gives exactly one full unit
    always_ff @(posedge clk) begin
      if (en) begin
        full[0] <= (num[l] == den[l]);
        rem[0]  <= (num[l] == den[l]) ? '0 : num[l];
        q[0]    <= '0;
      end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_step
      logic [NUM_W:0] dbl;
      logic           ge;

      always_comb begin
        dbl = {rem[k-1], 1'b0};
        ge  = (dbl >= {1'b0, den[l]});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k]  <= ge ? NUM_W'(dbl - {1'b0, den[l]}) : dbl[NUM_W-1:0];
          q[k]    <= {q[k-1][Q_W-2:0], ge};
          full[k] <= full[k-1];
        end
      end
    end

    assign quo[l] = full[Q_W] ? {1'b1, {Q_W{1'b0}}} : {1'b0, q[Q_W]};
  end

endmodule

### hw/rtl/srra_cordic_rot.sv
// Pipelined rotation-mode CORDIC: cosine and sine in Q30 of a 32-bit phase.
// Uses srra_pkg for the arctangent table, gain and widths.
module srra_cordic_rot #(
  parameter int LANES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        phase [LANES],
  output logic               out_valid,
  output logic signed [31:0] cos_q [LANES],
  output logic signed [31:0] sin_q [LANES]
);

  localparam int N = srra_pkg::STEPS;
  localparam int W = srra_pkg::ROT_W;
  localparam logic signed [W-1:0] QTR  = W'(64'sd1073741824);
  localparam logic signed [W-1:0] HALF = W'(64'sd2147483648);

  logic [N+1:0] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N:0], in_valid};
    end
  end

  assign out_valid = v[N+1];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [W-1:0] xr  [0:N];
    logic signed [W-1:0] yr  [0:N];
    logic signed [W-1:0] zr  [0:N];
    logic                neg [0:N];
    logic signed [W-1:0] z0;
    logic                n0;

    // Fold the phase into [-quarter, quarter] turn
    always_comb begin
      z0 = W'($signed(phase[l]));
      n0 = 1'b0;
      if (z0 > QTR) begin
        z0 = z0 - HALF;
        n0 = 1'b1;
      end else if (z0 < -QTR) begin
        z0 = z0 + HALF;
        n0 = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[0]  <= W'(srra_pkg::INV_GAIN);
        yr[0]  <= '0;
        zr[0]  <= z0;
        neg[0] <= n0;
      end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [W-1:0] AT = W'(srra_pkg::atan_tab(i));
      logic signed [W-1:0] dx, dy;

      assign dx = yr[i] >>> i;
      assign dy = xr[i] >>> i;

      always_ff @(posedge clk) begin
        if (en) begin
          if (zr[i] >= 0) begin
            xr[i+1] <= xr[i] - dx;
            yr[i+1] <= yr[i] + dy;
            zr[i+1] <= zr[i] - AT;
          end else begin
            xr[i+1] <= xr[i] + dx;
            yr[i+1] <= yr[i] - dy;
            zr[i+1] <= zr[i] + AT;
          end
          neg[i+1] <= neg[i];
        end
      end
    end

    // Undo the half-turn fold
    always_ff @(posedge clk) begin
      if (en) begin
        cos_q[l] <= neg[N] ? 32'(-xr[N]) : 32'(xr[N]);
        sin_q[l] <= neg[N] ? 32'(-yr[N]) : 32'(yr[N]);
      end
    end
  end

endmodule

### hw/rtl/srra_rotate.sv
// Sphere point and two-axis rotation: six register stages of Q30 products and sums.
// Uses srra_pkg for mulq, the CORDIC gain and widths.
module srra_rotate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [31:0]              cu,
  input  logic signed [31:0]              su,
  input  logic signed [31:0]              cv,
  input  logic signed [31:0]              sv,
  input  logic signed [31:0]              ca,
  input  logic signed [31:0]              sa,
  input  logic signed [31:0]              cb,
  input  logic signed [31:0]              sb,
  output logic                            out_valid,
  output logic signed [srra_pkg::Q_W-1:0] nx,
  output logic signed [srra_pkg::Q_W-1:0] nz,
  output logic signed [srra_pkg::Q_W-1:0] nyg
);

  localparam int W = srra_pkg::Q_W;

  logic [5:0] v;
  logic signed [W-1:0] ox, oy1, oz, oy2, oy3, m1, m2, m3, m4, nx3, tz, nx4, nx5;
  logic signed [W-1:0] k1, k2, k3, k4, ny, nz5;
  logic signed [31:0]  ca1, sa1, cb1, sb1, cb2, sb2, cb3, sb3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  assign out_valid = v[5];

  always_ff @(posedge clk) begin
    if (en) begin
      // point on the unit sphere
      ox  <= srra_pkg::mulq(cu, sv);
      oy1 <= W'(cv);
      oz  <= -srra_pkg::mulq(su, sv);
      ca1 <= ca;
      sa1 <= sa;
      cb1 <= cb;
      sb1 <= sb;
      // rotate about y
      m1  <= srra_pkg::mulq(ox, ca1);
      m2  <= srra_pkg::mulq(oz, sa1);
      m3  <= srra_pkg::mulq(ox, sa1);
      m4  <= srra_pkg::mulq(oz, ca1);
      oy2 <= oy1;
      cb2 <= cb1;
      sb2 <= sb1;
      nx3 <= m1 - m2;
      tz  <= -m3 - m4;
      oy3 <= oy2;
      cb3 <= cb2;
      sb3 <= sb2;
      // rotate about x
      k1  <= srra_pkg::mulq(oy3, cb3);
      k2  <= srra_pkg::mulq(tz, sb3);
      k3  <= srra_pkg::mulq(oy3, sb3);
      k4  <= srra_pkg::mulq(tz, cb3);
      nx4 <= nx3;
      ny  <= k1 + k2;
      nz5 <= k4 - k3;
      nx5 <= nx4;
      nyg <= srra_pkg::mulq(ny, srra_pkg::GAIN);
      nx  <= nx5;
      nz  <= nz5;
    end
  end

endmodule

### hw/rtl/srra_cordic_vec.sv
// Pipelined vectoring-mode CORDIC: angle of (x, y) in phase units and gain-scaled magnitude.
// Uses srra_pkg for the arctangent table, gain and widths.
module srra_cordic_vec #(
  parameter int SB_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [srra_pkg::VEC_W-1:0] x_in,
  input  logic signed [srra_pkg::VEC_W-1:0] y_in,
  input  logic [SB_W-1:0]                   sb_in,
  output logic                              out_valid,
  output logic signed [srra_pkg::VEC_W-1:0] angle,
  output logic signed [srra_pkg::VEC_W-1:0] mag,
  output logic [SB_W-1:0]                   sb_out
);

  localparam int N = srra_pkg::STEPS;
  localparam int W = srra_pkg::VEC_W;
  localparam logic signed [W-1:0] HALF = W'(64'sd2147483648);

  logic [N+1:0] v;
  logic signed [W-1:0] xr   [0:N];
  logic signed [W-1:0] yr   [0:N];
  logic signed [W-1:0] zr   [0:N];
  logic                spec [0:N];
  logic                sneg [0:N];
  logic signed [W-1:0] smag [0:N];
  logic [SB_W-1:0]     sb   [0:N];
  logic signed [W-1:0] absx, x0, y0, z0;
  logic                xneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N:0], in_valid};
    end
  end

  assign out_valid = v[N+1];

  // Turn a left-half vector by a half turn; the base angle seeds z
  always_comb begin
    xneg = x_in < 0;
    absx = xneg ? -x_in : x_in;
    x0   = xneg ? -x_in : x_in;
    y0   = xneg ? -y_in : y_in;
    if (!xneg) begin
      z0 = '0;
    end else if (y_in > 0) begin
      z0 = HALF;
    end else begin
      z0 = -HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr[0]   <= x0;
      yr[0]   <= y0;
      zr[0]   <= z0;
      spec[0] <= (y_in == 0);
      sneg[0] <= xneg;
      smag[0] <= W'(srra_pkg::mulq(34'(absx), srra_pkg::GAIN));
      sb[0]   <= sb_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [W-1:0] AT = W'(srra_pkg::atan_tab(i));
    logic signed [W-1:0] dx, dy;

    assign dx = yr[i] >>> i;
    assign dy = xr[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (yr[i] > 0) begin
          xr[i+1] <= xr[i] + dx;
          yr[i+1] <= yr[i] - dy;
          zr[i+1] <= zr[i] + AT;
        end else begin
          xr[i+1] <= xr[i] - dx;
          yr[i+1] <= yr[i] + dy;
          zr[i+1] <= zr[i] - AT;
        end
        spec[i+1] <= spec[i];
        sneg[i+1] <= sneg[i];
        smag[i+1] <= smag[i];
        sb[i+1]   <= sb[i];
      end
    end
  end

  // A vector on the x axis bypasses the iterations
  always_ff @(posedge clk) begin
    if (en) begin
      if (spec[N]) begin
        angle <= sneg[N] ? HALF : '0;
        mag   <= smag[N];
      end else begin
        angle <= zr[N];
        mag   <= xr[N];
      end
      sb_out <= sb[N];
    end
  end

endmodule

### hw/rtl/sphere_rotation_remap_address_core.sv
// Top level of the sphere rotation remap address core: config registers, pipeline, output skid.
// Depends on srra_pkg, srra_div, srra_cordic_rot, srra_rotate and srra_cordic_vec.

// For each output pixel (out_x, out_y) of an equirectangular map this core returns the source
// pixel (src_x, src_y) to fetch when the sphere is rotated about its y axis by rot_y_angle
// and then about its x axis by rot_x_angle (both in 1/65536 turn). The pipeline takes one
// item per clock while coord_stall is low; the depth comes from a two-lane 33-stage phase
// divider, a 32-stage sine/cosine CORDIC, six stages of rotation products and two 32-stage
// vectoring CORDICs in series. The whole pipeline advances on one enable; a two-entry
// output buffer (output register plus skid) lets new items enter while a finished result
// waits, and coord_stall rises only once both entries hold results. Image sizes are clamped
// to [2, MAX_DIM] when written and stored as size minus one; coordinates past the image
// edge are taken as the last column or row. Longitude at the poles is zero. Write
// configuration only while no item is in flight; cfg_ready is always high and writes to
// unknown indexes are dropped.
module sphere_rotation_remap_address_core #(
  parameter int MAX_DIM = srra_pkg::MAX_DIM
) (
  input  logic        clk,
  input  logic        rst,
  // pixel coordinate channel
  input  logic        coord_valid,
  output logic        coord_stall,
  input  logic [11:0] out_x,
  input  logic [11:0] out_y,
  // source address channel
  output logic        addr_valid,
  input  logic        addr_stall,
  output logic [11:0] src_x,
  output logic [11:0] src_y,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DW = srra_pkg::DIM_W;
  localparam int VW = srra_pkg::VEC_W;
  localparam int QW = srra_pkg::Q_W;
  localparam logic signed [36:0] FULL_TURN = 37'sd4294967296;
  localparam logic signed [VW-1:0] HALF_TURN = VW'(64'sd2147483648);

  // ---------------------------------------------------------------
  // Configuration registers. Sizes are stored clamped, minus one.
  // ---------------------------------------------------------------
  logic [15:0]   rot_y;
  logic [15:0]   rot_x;
  logic [DW-1:0] wm1;
  logic [DW-1:0] hm1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_y <= '0;
      rot_x <= '0;
      wm1   <= srra_pkg::clamp_m1(13'd4096, MAX_DIM);
      hm1   <= srra_pkg::clamp_m1(13'd2048, MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srra_pkg::REG_ROT_Y: rot_y <= cfg_data;
        srra_pkg::REG_ROT_X: rot_x <= cfg_data;
        srra_pkg::REG_MAP_W: wm1 <= srra_pkg::clamp_m1(cfg_data[DW-1:0], MAX_DIM);
        srra_pkg::REG_MAP_H: hm1 <= srra_pkg::clamp_m1(cfg_data[DW-1:0], MAX_DIM);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline enable: hold everything while the skid entry is full.
  // ---------------------------------------------------------------
  logic skid_valid;
  logic adv;

  assign adv         = !skid_valid;
  assign coord_stall = skid_valid;

  // ---------------------------------------------------------------
  // Stage group 1: clamp coordinates, divide into phases.
  // U = x * 2^32 / (w-1) mod 2^32, V = floor(y * 2^32 / (h-1)) / 2.
  // ---------------------------------------------------------------
  logic [DW-1:0] div_num [2];
  logic [DW-1:0] div_den [2];
  logic [32:0]   div_quo [2];
  logic          div_valid;

  always_comb begin
    div_num[0] = ({1'b0, out_x} > wm1) ? wm1 : {1'b0, out_x};
    div_num[1] = ({1'b0, out_y} > hm1) ? hm1 : {1'b0, out_y};
    div_den[0] = wm1;
    div_den[1] = hm1;
  end

  srra_div #(
    .LANES (2),
    .NUM_W (DW),
    .Q_W   (srra_pkg::PH_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (coord_valid),
    .num       (div_num),
    .den       (div_den),
    .out_valid (div_valid),
    .quo       (div_quo)
  );

  // ---------------------------------------------------------------
  // Stage group 2: sine and cosine of U, V and both rotation angles.
  // ---------------------------------------------------------------
  logic [31:0]        phase [4];
  logic signed [31:0] cos_q [4];
  logic signed [31:0] sin_q [4];
  logic               sc_valid;

  always_comb begin
    phase[0] = div_quo[0][31:0];
    phase[1] = div_quo[1][32:1];
    phase[2] = {rot_y, 16'h0000};
    phase[3] = {rot_x, 16'h0000};
  end

  srra_cordic_rot #(
    .LANES (4)
  ) u_sincos (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (div_valid),
    .phase     (phase),
    .out_valid (sc_valid),
    .cos_q     (cos_q),
    .sin_q     (sin_q)
  );

  // ---------------------------------------------------------------
  // Stage group 3: sphere point, rotate about y then x.
  // ---------------------------------------------------------------
  logic signed [QW-1:0] nx, nz, nyg;
  logic                 rot_valid;

  srra_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sc_valid),
    .cu        (cos_q[0]),
    .su        (sin_q[0]),
    .cv        (cos_q[1]),
    .sv        (sin_q[1]),
    .ca        (cos_q[2]),
    .sa        (sin_q[2]),
    .cb        (cos_q[3]),
    .sb        (sin_q[3]),
    .out_valid (rot_valid),
    .nx        (nx),
    .nz        (nz),
    .nyg       (nyg)
  );

  // ---------------------------------------------------------------
  // Stage group 4: longitude from (nx, nz). Carry gained ny and the
  // sign facts of nx, nz that the longitude fix-up needs.
  // ---------------------------------------------------------------
  localparam int SB1_W = QW + 3;

  logic [SB1_W-1:0]     sb1_in, sb1_out;
  logic signed [VW-1:0] ang1, mag1;
  logic                 v1_valid;

  assign sb1_in = {nyg, nz[QW-1], (nz == '0), (!nx[QW-1] && (nx != '0))};

  srra_cordic_vec #(
    .SB_W (SB1_W)
  ) u_lon (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (rot_valid),
    .x_in      (VW'(nx)),
    .y_in      (VW'(nz)),
    .sb_in     (sb1_in),
    .out_valid (v1_valid),
    .angle     (ang1),
    .mag       (mag1),
    .sb_out    (sb1_out)
  );

  // Longitude phase t in [0, 2^32]
  logic signed [36:0] ta;
  logic [32:0]        t33;
  logic               nz_neg, nz_zero, nx_pos;
  logic signed [QW-1:0] nyg1;

  always_comb begin
    nyg1    = sb1_out[SB1_W-1:3];
    nz_neg  = sb1_out[2];
    nz_zero = sb1_out[1];
    nx_pos  = sb1_out[0];
    if (nz_zero && nx_pos) begin
      ta = FULL_TURN;
    end else if (nz_neg) begin
      ta = 37'(ang1) + FULL_TURN;
    end else begin
      ta = 37'(ang1);
    end
    if (ta < 0) begin
      t33 = '0;
    end else if (ta > FULL_TURN) begin
      t33 = 33'h1_0000_0000;
    end else begin
      t33 = ta[32:0];
    end
  end

  // ---------------------------------------------------------------
  // Stage group 5: colatitude from (gained ny, magnitude).
  // ---------------------------------------------------------------
  logic signed [VW-1:0] ang2, mag2;
  logic [32:0]          t_fin;
  logic                 v2_valid;

  srra_cordic_vec #(
    .SB_W (33)
  ) u_colat (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v1_valid),
    .x_in      (VW'(nyg1)),
    .y_in      (mag1),
    .sb_in     (t33),
    .out_valid (v2_valid),
    .angle     (ang2),
    .mag       (mag2),
    .sb_out    (t_fin)
  );

  // ---------------------------------------------------------------
  // Final stage: clamp colatitude to [0, 2^31], scale both phases
  // to pixels and truncate.
  // ---------------------------------------------------------------
  logic [31:0] c32;
  logic [45:0] px;
  logic [44:0] py;
  logic        last_valid;
  logic [11:0] last_x, last_y;
  logic [11:0] skid_x, skid_y;
  logic        out_take;

  always_comb begin
    if (ang2 < 0) begin
      c32 = '0;
    end else if (ang2 > HALF_TURN) begin
      c32 = 32'h8000_0000;
    end else begin
      c32 = ang2[31:0];
    end
    px = 46'(t_fin) * 46'(wm1);
    py = 45'(c32) * 45'(hm1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else if (adv) begin
      last_valid <= v2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_x <= px[43:32];
      last_y <= py[42:31];
    end
  end

  // ---------------------------------------------------------------
  // Output register and skid entry.
  // ---------------------------------------------------------------
  assign out_take = addr_valid && !addr_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain the skid entry into the output register
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (last_valid) begin
      if (addr_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        addr_valid <= 1'b1;
      end
    end else if (out_take) begin
      addr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        src_x <= skid_x;
        src_y <= skid_y;
      end
    end else if (last_valid) begin
      if (addr_valid && !out_take) begin
        skid_x <= last_x;
        skid_y <= last_y;
      end else begin
        src_x <= last_x;
        src_y <= last_y;
      end
    end
  end

endmodule

### hw/rtl/srra_checker.sv
// Port-level checks for sphere_rotation_remap_address_core, bound to the top level.
// Depends only on the top level's ports.
module srra_checker (
  input logic        clk,
  input logic        rst,
  input logic        coord_stall,
  input logic        addr_valid,
  input logic        addr_stall,
  input logic [11:0] src_x,
  input logic [11:0] src_y
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    addr_valid && addr_stall |=> addr_valid && $stable(src_x) && $stable(src_y))
    else $error("result changed while stalled");

  // input stalls only with a result pending
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    coord_stall |-> addr_valid)
    else $error("input stalled with no result pending");

  // input stall rises only after an output stall
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(coord_stall) |-> $past(addr_valid && addr_stall))
    else $error("input stall without output back-pressure");

  // reset empties the output side
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !addr_valid && !coord_stall)
    else $error("output not empty after reset");

endmodule

bind sphere_rotation_remap_address_core srra_checker u_srra_checker (
  .clk         (clk),
  .rst         (rst),
  .coord_stall (coord_stall),
  .addr_valid  (addr_valid),
  .addr_stall  (addr_stall),
  .src_x       (src_x),
  .src_y       (src_y)
);

### dv/tb_top.sv
// Self-checking testbench for sphere_rotation_remap_address_core.
// Drives pixel coordinates and checks source addresses against a bit-exact fixed-point predictor.
// Depends on srra_pkg (register indexes) and the core RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY = 136;

  typedef struct {
    logic [11:0] sx;
    logic [11:0] sy;
  } src_addr_t;

  // Directed row: config to apply first (NO_REG means none), coordinate,
  // and an optional typed-in expected address.
  typedef struct {
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    logic [11:0] px;
    logic [11:0] py;
    bit          known;
    logic [11:0] kx;
    logic [11:0] ky;
  } row_t;

  localparam logic [2:0] NO_REG  = 3'd7;
  localparam logic [2:0] BAD_REG = 3'd5;

  logic        clk;
  logic        rst;
  logic        coord_valid;
  logic        coord_stall;
  logic [11:0] out_x;
  logic [11:0] out_y;
  logic        addr_valid;
  logic        addr_stall;
  logic [11:0] src_x;
  logic [11:0] src_y;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // Predictor copy of the configuration registers
  longint yaw_q, pitch_q, width_q, height_q;

  src_addr_t addr_queue[$];
  bit        failed;
  bit        stim_done;

  // CORDIC arctangent table in phase units (2^32 per turn)
  longint atan_lut[30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  sphere_rotation_remap_address_core i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Arithmetic shift with floor semantics on 64-bit signed values
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sra(a * b, 30);
  endfunction

  // Rotation-mode CORDIC: cosine and sine of a 32-bit phase in Q30
  function automatic void phase_sincos(longint phase, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = phase & 64'hFFFF_FFFF;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Vectoring-mode CORDIC: angle of (x, y) in phase units, magnitude carries gain
  function automatic longint vector_phase(longint x, longint y, output longint mag);
    longint base, z, dx, dy;
    base = 0;
    z = 0;
    if (y == 0) begin
      mag = qmul(x < 0 ? -x : x, 1768195363);
      return x < 0 ? 64'sd2147483648 : 0;
    end
    if (x < 0) begin
      base = y > 0 ? 64'sd2147483648 : -64'sd2147483648;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 30; i++) begin
      dx = sra(y, i);
      dy = sra(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    mag = x;
    return base + z;
  endfunction

  function automatic longint dim_m1(longint d);
    if (d < 2) return 1;
    if (d > 4096) return 4095;
    return d - 1;
  endfunction

  // Full remap of one output pixel to its source address
  function automatic src_addr_t remap_pixel(logic [11:0] px, logic [11:0] py);
    longint wm, hm, x, y, cu, su, cv, sv, ca, sa, cb, sb;
    longint ox, oy, oz, nx, tz, ny, nz, mag, unused, t, c;
    src_addr_t r;
    wm = dim_m1(width_q);
    hm = dim_m1(height_q);
    x = px;
    y = py;
    if (x > wm) x = wm;
    if (y > hm) y = hm;
    phase_sincos((x << 32) / wm, cu, su);
    phase_sincos((y << 31) / hm, cv, sv);
    phase_sincos(yaw_q << 16, ca, sa);
    phase_sincos(pitch_q << 16, cb, sb);
    ox = qmul(cu, sv);
    oy = cv;
    oz = -qmul(su, sv);
    nx = qmul(ox, ca) - qmul(oz, sa);
    tz = -qmul(ox, sa) - qmul(oz, ca);
    ny = qmul(oy, cb) + qmul(tz, sb);
    nz = -qmul(oy, sb) + qmul(tz, cb);
    t = vector_phase(nx, nz, mag);
    if (nz == 0 && nx > 0) t = 64'sd4294967296;
    else if (nz < 0) t += 64'sd4294967296;
    if (t < 0) t = 0;
    if (t > 64'sd4294967296) t = 64'sd4294967296;
    c = vector_phase(qmul(ny, 1768195363), mag, unused);
    if (c < 0) c = 0;
    if (c > 64'sd2147483648) c = 64'sd2147483648;
    r.sx = 12'((t * wm) >> 32);
    r.sy = 12'((c * hm) >> 31);
    return r;
  endfunction

  // Random gap: mostly none or short, occasionally long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // mirror the register into the predictor
    case (idx)
      srra_pkg::REG_ROT_Y: yaw_q    = val;
      srra_pkg::REG_ROT_X: pitch_q  = val;
      srra_pkg::REG_MAP_W: width_q  = val & 16'h1FFF;
      srra_pkg::REG_MAP_H: height_q = val & 16'h1FFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every expected address has come back, then let the pipe drain
  task automatic drain_pipe();
    while (addr_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Present one item and hold it until accepted; expectation queued on acceptance
  task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit known,
                            logic [11:0] kx, logic [11:0] ky);
    src_addr_t e;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      coord_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    coord_valid <= 1'b1;
    out_x <= px;
    out_y <= py;
    @(posedge clk);
    while (coord_stall) @(posedge clk);
    e = remap_pixel(px, py);
    if (known && (e.sx != kx || e.sy != ky))
      $error("predictor disagrees with table row: %0d,%0d vs %0d,%0d", e.sx, e.sy, kx, ky);
    if (known) begin
      e.sx = kx;
      e.sy = ky;
    end
    addr_queue.push_back(e);
  endtask

  task automatic release_valid();
    @(negedge clk);
    coord_valid <= 1'b0;
  endtask

  // Directed rows: extremes, poles, clamping, every register
  row_t plan[$] = '{
    '{NO_REG,              16'd0,     12'd0,    12'd0,    1'b0, 12'd0, 12'd0},
    '{NO_REG,              16'd0,     12'd4095, 12'd2047, 1'b0, 12'd0, 12'd0},
    '{NO_REG,              16'd0,     12'd2048, 12'd1024, 1'b0, 12'd0, 12'd0},
    '{NO_REG,              16'd0,     12'd4095, 12'd4095, 1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_ROT_Y, 16'd16384, 12'd1000, 12'd700,  1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_ROT_Y, 16'd65535, 12'd0,    12'd1023, 1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_ROT_X, 16'd16384, 12'd0,    12'd0,    1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_ROT_X, 16'd65535, 12'd4095, 12'd2047, 1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_ROT_X, 16'd32768, 12'd1234, 12'd567,  1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_MAP_W, 16'd2,     12'd1,    12'd1000, 1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_MAP_W, 16'd0,     12'd4095, 12'd5,    1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_MAP_H, 16'd2,     12'd0,    12'd4095, 1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_MAP_H, 16'hFFFF,  12'd2,    12'd3000, 1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_MAP_W, 16'h1FFF,  12'd4095, 12'd4095, 1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_ROT_Y, 16'd0,     12'd2047, 12'd2048, 1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_ROT_X, 16'd0,     12'd3071, 12'd100,  1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_MAP_H, 16'd4096,  12'd0,    12'd4095, 1'b0, 12'd0, 12'd0},
    '{srra_pkg::REG_MAP_W, 16'd4096,  12'd4095, 12'd0,    1'b0, 12'd0, 12'd0}
  };

  // Stimulus
  initial begin
    int phases;
    int items;
    rst = 1'b1;
    coord_valid = 1'b0;
    out_x = '0;
    out_y = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failed = 1'b0;
    stim_done = 1'b0;
    yaw_q = 0;
    pitch_q = 0;
    width_q = 4096;
    height_q = 2048;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table: a register write only once the pipe is empty
    foreach (plan[k]) begin
      if (plan[k].reg_idx != NO_REG) begin
        release_valid();
        drain_pipe();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end
      send_pixel(plan[k].px, plan[k].py, plan[k].known, plan[k].kx, plan[k].ky);
    end
    release_valid();
    drain_pipe();
    write_reg(BAD_REG, 16'hABCD);  // unknown index, dropped
    send_pixel(12'd77, 12'd88, 1'b0, 12'd0, 12'd0);

    // Random phases: new angles and sizes, then a burst of pixels
    for (phases = 0; phases < 10; phases++) begin
      release_valid();
      drain_pipe();
      write_reg(srra_pkg::REG_ROT_Y, 16'($urandom));
      write_reg(srra_pkg::REG_ROT_X, 16'($urandom));
      // sizes mostly in [2, 4096], one time in four any 13-bit value, maybe out-of-range
      write_reg(srra_pkg::REG_MAP_W, ($urandom_range(0, 3) == 0)
                ? 16'($urandom_range(0, 8191)) : 16'($urandom_range(2, 4096)));
      write_reg(srra_pkg::REG_MAP_H, ($urandom_range(0, 3) == 0)
                ? 16'($urandom_range(0, 8191)) : 16'($urandom_range(2, 4096)));
      for (items = 0; items < 100; items++) begin
        // most pixels inside the map, some past its edge
        if ($urandom_range(0, 9) == 0)
          send_pixel(12'($urandom), 12'($urandom), 1'b0, 12'd0, 12'd0);
        else
          send_pixel(12'($urandom_range(0, int'(dim_m1(width_q)))),
                     12'($urandom_range(0, int'(dim_m1(height_q)))), 1'b0, 12'd0, 12'd0);
      end
    end
    release_valid();
    stim_done = 1'b1;
  end

  // Receiver: random stall pattern with quiet stretches
  initial begin
    int gap;
    addr_stall = 1'b0;
    @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        addr_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      addr_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // Check each accepted address against the oldest expectation
  always @(posedge clk) begin
    src_addr_t e;
    if (!rst && addr_valid && !addr_stall) begin
      if (addr_queue.size() == 0) begin
        $error("unexpected address: src_x %0d src_y %0d", src_x, src_y);
        failed = 1'b1;
      end else begin
        e = addr_queue.pop_front();
        if (src_x !== e.sx) begin
          $error("src_x mismatch: expected %0d actual %0d", e.sx, src_x);
          failed = 1'b1;
        end
        if (src_y !== e.sy) begin
          $error("src_y mismatch: expected %0d actual %0d", e.sy, src_y);
          failed = 1'b1;
        end
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (addr_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (!failed && addr_queue.size() == 0)
      $display("[sphere_rotation_remap_address_core] OK");
    else
      $display("[sphere_rotation_remap_address_core] ERROR");
    $finish;
  end

  // Timeout guard
  initial begin
    #2000000;
    $display("[sphere_rotation_remap_address_core] ERROR");
    $finish;
  end

endmodule
